@@ hdl/lcdw_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdw_pkg
// Shared types and constants for the character-LCD decimal readout writer.
// ----------------------------------------------------------------------------
package lcdw_pkg;

    localparam logic [7:0] SET_ADDR   = 8'h80;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [9:0] MAX_SHOWN  = 10'd999;

    localparam logic REQ_NUMBER = 1'b0;
    localparam logic REQ_CHAR   = 1'b1;

    // One classified request as it waits between the front and the back.
    typedef struct packed {
        logic       is_char;
        logic [6:0] addr;
        logic [7:0] first_byte;
        logic [3:0] tens;
        logic [3:0] units;
    } t_job;

    function automatic logic [6:0] place_of_source(input logic [2:0] src);
        logic [6:0] place;
        case (src)
            3'd0:    place = 7'h0D;
            3'd1:    place = 7'h01;
            3'd2:    place = 7'h4D;
            3'd3:    place = 7'h41;
            3'd4:    place = 7'h07;
            3'd5:    place = 7'h47;
            default: place = 7'h00;
        endcase
        return place;
    endfunction

endpackage

@@ hdl/lcd_decimal_readout_writer.sv @@
// ----------------------------------------------------------------------------
// lcd_decimal_readout_writer
// Turns display requests into character-LCD bus writes.
// ----------------------------------------------------------------------------
// A number request produces four writes (set address, then hundreds, tens and
// units as ASCII digits) and a character request produces two (set address,
// then the character). The back end emits one write per cycle while its output
// is popped or empty and the queue is not empty; this write sequencer sets the
// sustained rate. Requests are accepted every cycle while the queue of
// QUEUE_DEPTH classified requests has room.
module lcd_decimal_readout_writer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_req_type,
    input  logic [9:0] i_value,
    input  logic [2:0] i_source,
    input  logic [7:0] i_char_code,
    input  logic [6:0] i_position,
    output logic       empty,
    input  logic       pop,
    output logic       o_is_data,
    output logic [7:0] o_bus_byte,
    output logic       o_last
);
    import lcdw_pkg::*;

    t_job job;
    t_job head;
    logic head_empty;
    logic head_rd;
    logic accept;

    assign accept = push && !full;

    lcdw_front u_front (
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .i_source    (i_source),
        .i_char_code (i_char_code),
        .i_position  (i_position),
        .o_job       (job)
    );

    lcdw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (accept),
        .i_wr_job (job),
        .o_full   (full),
        .i_rd     (head_rd),
        .o_head   (head),
        .o_empty  (head_empty)
    );

    lcdw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_empty (head_empty),
        .o_head_rd    (head_rd),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_is_data    (o_is_data),
        .o_bus_byte   (o_bus_byte),
        .o_last       (o_last)
    );

endmodule

@@ hdl/lcdw_front.sv @@
// ----------------------------------------------------------------------------
// lcdw_front
// Classifies a request and splits a number into its three decimal digits.
// ----------------------------------------------------------------------------
module lcdw_front (
    input  logic          i_req_type,
    input  logic [9:0]    i_value,
    input  logic [2:0]    i_source,
    input  logic [7:0]    i_char_code,
    input  logic [6:0]    i_position,
    output lcdw_pkg::t_job o_job
);
    import lcdw_pkg::*;

    logic [9:0] sat;
    logic [3:0] hund;
    logic [9:0] hund_part;
    logic [6:0] rem;
    logic [3:0] tens;
    logic [6:0] tens_part;
    logic [3:0] units;

    always_comb begin
        sat = (i_value > MAX_SHOWN) ? MAX_SHOWN : i_value;
        hund = 4'd0;
        hund_part = 10'd0;
        for (int k = 1; k <= 9; k++) begin
            if (sat >= 10'(k * 100)) begin
                hund = 4'(k);
                hund_part = 10'(k * 100);
            end
        end
        rem = 7'(sat - hund_part);
        tens = 4'd0;
        tens_part = 7'd0;
        for (int k = 1; k <= 9; k++) begin
            if (rem >= 7'(k * 10)) begin
                tens = 4'(k);
                tens_part = 7'(k * 10);
            end
        end
        units = 4'(rem - tens_part);
    end

    always_comb begin
        o_job = '0;
        o_job.is_char = (i_req_type == REQ_CHAR);
        if (i_req_type == REQ_CHAR) begin
            o_job.addr       = i_position;
            o_job.first_byte = i_char_code;
        end else begin
            o_job.addr       = place_of_source(i_source);
            o_job.first_byte = ASCII_ZERO + {4'd0, hund};
            o_job.tens       = tens;
            o_job.units      = units;
        end
    end

endmodule

@@ hdl/lcdw_queue.sv @@
// ----------------------------------------------------------------------------
// lcdw_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module lcdw_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  lcdw_pkg::t_job i_wr_job,
    output logic           o_full,
    input  logic           i_rd,
    output lcdw_pkg::t_job o_head,
    output logic           o_empty
);
    import lcdw_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

endmodule

@@ hdl/lcdw_back.sv @@
// ----------------------------------------------------------------------------
// lcdw_back
// Walks through the bus writes of the request at the head of the queue.
// ----------------------------------------------------------------------------
module lcdw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lcdw_pkg::t_job i_head,
    input  logic           i_head_empty,
    output logic           o_head_rd,
    output logic           o_empty,
    input  logic           i_pop,
    output logic           o_is_data,
    output logic [7:0]     o_bus_byte,
    output logic           o_last
);
    import lcdw_pkg::*;

    logic [1:0] r_step, n_step;
    logic       r_valid, n_valid;
    logic       r_is_data;
    logic [7:0] r_byte;
    logic       r_last;
    logic       advance;
    logic       emit;
    logic       step_last;
    logic [7:0] step_byte;

    assign advance = !r_valid || i_pop;
    assign emit    = advance && !i_head_empty;

    always_comb begin
        step_last = i_head.is_char ? (r_step == 2'd1) : (r_step == 2'd3);
        case (r_step)
            2'd0:    step_byte = SET_ADDR | {1'b0, i_head.addr};
            2'd1:    step_byte = i_head.first_byte;
            2'd2:    step_byte = ASCII_ZERO + {4'd0, i_head.tens};
            default: step_byte = ASCII_ZERO + {4'd0, i_head.units};
        endcase
    end

    always_comb begin
        n_step  = r_step;
        n_valid = r_valid;
        if (advance) begin
            n_valid = !i_head_empty;
        end
        if (emit) begin
            n_step = step_last ? 2'd0 : r_step + 2'd1;
        end
    end

    assign o_head_rd = emit && step_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_is_data <= (r_step != 2'd0);
            r_byte    <= step_byte;
            r_last    <= step_last;
        end
    end

    assign o_empty    = !r_valid;
    assign o_is_data  = r_is_data;
    assign o_bus_byte = r_byte;
    assign o_last     = r_last;

endmodule
